/* design/gn3_pkg.sv */
// gn3_pkg: shared widths, codes and the queued item type of the gradient noise unit
// used by gn3_front, gn3_back and gradient_noise_3d_unit; no dependencies
package gn3_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int BYTE_W      = 8;
    localparam int CELL_W      = 8;
    localparam int COORD_W     = 32;
    localparam int NOISE_W     = 17;
    localparam int NOISE_MAX   = 65536;

    localparam int ONE  = 1 << FRAC_BITS;
    localparam int HALF = 1 << (FRAC_BITS - 1);

    // fade internals, fade weights, gradient and blend values
    localparam int A_W  = FRAC_BITS + 5;
    localparam int FD_W = FRAC_BITS + 3;
    localparam int V_W  = FRAC_BITS + 5;

    // output rescale to sixteen fraction bits
    localparam int OSH = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 0;
    localparam int OML = (FRAC_BITS < 15) ? 15 - FRAC_BITS : 0;
    localparam int RND = (OSH > 0) ? (1 << (OSH - 1)) : 0;
    localparam int O_W = V_W + OML + 2;

    // stream packing
    localparam int OFS_IDX   = 0;
    localparam int OFS_VAL   = OFS_IDX + IDX_W;
    localparam int OFS_X     = OFS_VAL + BYTE_W;
    localparam int S_DATA_W  = ((OFS_X + 3 * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((NOISE_W + 7) / 8) * 8;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic                               is_eval;
        logic [IDX_W-1:0]                   tbl_idx;
        logic [BYTE_W-1:0]                  tbl_val;
        logic [2:0][CELL_W-1:0]             cidx;
        logic [2:0][FRAC_BITS-1:0]          frac;
    } t_item;

endpackage

/* design/gradient_noise_3d_unit.sv */
// gradient_noise_3d_unit: top level of the 3d gradient noise evaluator
// depends on gn3_pkg, gn3_front, gn3_back (which uses gn3_ram)
//
// channel    dir   handshake                    payload
// s_axis     in    i_s_axis_tvalid/o_s_axis_tready  tdata: index, value, x, y, z; tuser: cmd
// m_axis     out   o_m_axis_tvalid/i_m_axis_tready  tdata: noise_value
//
// one word per cycle sustained without backpressure; results pass queue, r1 to r7, r_out
// the seven table copies (two read ports each) let all fourteen lookups run per cycle
// a table write takes one slot and reaches each copy at the stage that reads it
// reset clears control only; table entries are undefined until written, no clearing pass
// backpressure freezes the pipeline; a four-word queue keeps the input side taking words
module gradient_noise_3d_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // table_index, table_value, pos_x, pos_y, pos_z
    input  logic [gn3_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // cmd
    input  logic [0:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // noise_value
    output logic [gn3_pkg::M_DATA_W-1:0]   o_m_axis_tdata
);

    gn3_pkg::t_item              w_head;
    logic                        w_head_vld;
    logic                        w_pop;
    logic [gn3_pkg::NOISE_W-1:0] w_noise;

    gn3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_kind     (i_s_axis_tuser[0]),
        .o_head     (w_head),
        .o_head_vld (w_head_vld),
        .i_pop      (w_pop)
    );

    gn3_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_head_vld (w_head_vld),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_noise    (w_noise)
    );

    assign o_m_axis_tdata = gn3_pkg::M_DATA_W'(w_noise);

endmodule

/* design/gn3_ram.sv */
// gn3_ram: generic memory, one write port and two registered read ports
// no dependencies
module gn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd0 <= r_mem[i_raddr0];
            r_rd1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rd0;
    assign o_rdata1 = r_rd1;

endmodule

/* design/gn3_front.sv */
// gn3_front: accepts input words, splits coordinates into cell and fraction
// and queues the classified items; depends on gn3_pkg
module gn3_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [gn3_pkg::S_DATA_W-1:0]   i_data,
    input  logic                           i_kind,
    output gn3_pkg::t_item                 o_head,
    output logic                           o_head_vld,
    input  logic                           i_pop
);

    localparam int F = gn3_pkg::FRAC_BITS;

    gn3_pkg::t_item              r_q [gn3_pkg::QDEPTH];
    logic [gn3_pkg::QPTR_W-1:0]  r_wp;
    logic [gn3_pkg::QPTR_W-1:0]  r_rp;
    logic [gn3_pkg::QPTR_W:0]    r_cnt;
    logic [gn3_pkg::QPTR_W:0]    n_cnt;
    gn3_pkg::t_item              w_item;
    logic                        w_push;

    always_comb begin
        logic [gn3_pkg::COORD_W-1:0] c;
        w_item.is_eval = (i_kind == gn3_pkg::CMD_EVAL);
        w_item.tbl_idx = i_data[gn3_pkg::OFS_IDX +: gn3_pkg::IDX_W];
        w_item.tbl_val = i_data[gn3_pkg::OFS_VAL +: gn3_pkg::BYTE_W];
        for (int i = 0; i < 3; i++) begin
            c = i_data[gn3_pkg::OFS_X + i * gn3_pkg::COORD_W +: gn3_pkg::COORD_W];
            w_item.cidx[i] = c[F +: gn3_pkg::CELL_W];
            w_item.frac[i] = c[F-1:0];
        end
    end

    assign o_ready    = (r_cnt != (gn3_pkg::QPTR_W+1)'(gn3_pkg::QDEPTH));
    assign w_push     = i_valid && o_ready;
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        case ({w_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (gn3_pkg::QPTR_W+1)'(gn3_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (gn3_pkg::QPTR_W+1)'(gn3_pkg::QDEPTH)) |-> !o_ready)
        else $error("ready while queue full");

endmodule

/* design/gn3_back.sv */
// gn3_back: hash lookups over replicated tables, fade, gradients, blends
// and output scaling in one stalling pipeline; depends on gn3_pkg and gn3_ram
module gn3_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gn3_pkg::t_item                i_head,
    input  logic                          i_head_vld,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gn3_pkg::NOISE_W-1:0]   o_noise
);

    localparam int F    = gn3_pkg::FRAC_BITS;
    localparam int IW   = gn3_pkg::IDX_W;
    localparam int AW   = gn3_pkg::A_W;
    localparam int FDW  = gn3_pkg::FD_W;
    localparam int VW   = gn3_pkg::V_W;
    localparam int OW   = gn3_pkg::O_W;
    localparam int BW   = gn3_pkg::BYTE_W;

    function automatic logic signed [VW-1:0] lerp(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b,
                                                   input logic signed [FDW-1:0] wt);
        logic signed [VW:0]       d;
        logic signed [VW+FDW:0]   p;
        d = {b[VW-1], b} - {a[VW-1], a};
        p = d * wt;
        p = p + (VW+FDW+1)'(gn3_pkg::HALF);
        return a + p[F +: VW];
    endfunction

    function automatic logic signed [VW-1:0] grad(input logic [3:0] h,
                                                   input logic signed [VW-1:0] x,
                                                   input logic signed [VW-1:0] y,
                                                   input logic signed [VW-1:0] z);
        logic signed [VW-1:0] u;
        logic signed [VW-1:0] v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        u = h[0] ? -u : u;
        v = h[1] ? -v : v;
        return u + v;
    endfunction

    logic en;
    logic [7:1] r_vld;
    logic [7:1] r_eval;
    logic       r_out_vld;
    logic [gn3_pkg::NOISE_W-1:0] r_out;

    gn3_pkg::t_item r1_item;
    gn3_pkg::t_item r2_item;
    logic signed [AW-1:0]  r1_ta [3];
    logic [F:0]            r1_t2 [3];
    logic signed [AW-1:0]  r2_b  [3];
    logic [F:0]            r2_t3 [3];
    logic [2:0][F-1:0]     r3_frac;
    logic signed [FDW-1:0] r3_fd [3];
    logic signed [FDW-1:0] r4_fd [3];
    logic signed [FDW-1:0] r5_fd [3];
    logic signed [FDW-1:0] r6_fd [3];
    logic signed [VW-1:0]  r4_g [8];
    logic signed [VW-1:0]  r5_l [4];
    logic signed [VW-1:0]  r6_m [2];
    logic signed [VW-1:0]  r7_n;

    logic signed [AW-1:0]  w_ta [3];
    logic [F:0]            w_t2 [3];
    logic signed [AW-1:0]  w_b  [3];
    logic [F:0]            w_t3 [3];
    logic signed [FDW-1:0] w_fd [3];
    logic signed [VW-1:0]  w_g  [8];
    logic [gn3_pkg::NOISE_W-1:0] w_out;

    logic [BW-1:0] rd [7][2];
    logic [IW-1:0] ra [7];
    logic [IW-1:0] w_base0;
    logic          we0;
    logic          we1;
    logic          we2;

    assign en    = !r_out_vld || i_ready;
    assign o_pop = en && i_head_vld;

    // table copies: level 0 by cell x, level 1 by a and b, level 2 by corner bases
    assign w_base0 = IW'(i_head.cidx[0]);
    assign ra[0]   = w_base0;
    assign ra[1]   = IW'(rd[0][0]) + IW'(r1_item.cidx[1]);
    assign ra[2]   = IW'(rd[0][1]) + IW'(r1_item.cidx[1]);
    assign ra[3]   = IW'(rd[1][0]) + IW'(r2_item.cidx[2]);
    assign ra[4]   = IW'(rd[1][1]) + IW'(r2_item.cidx[2]);
    assign ra[5]   = IW'(rd[2][0]) + IW'(r2_item.cidx[2]);
    assign ra[6]   = IW'(rd[2][1]) + IW'(r2_item.cidx[2]);
    assign we0 = o_pop && !i_head.is_eval;
    assign we1 = en && r_vld[1] && !r1_item.is_eval;
    assign we2 = en && r_vld[2] && !r2_item.is_eval;

    gn3_ram #(.WIDTH(BW), .DEPTH(gn3_pkg::TABLE_DEPTH)) u_ram0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(i_head.tbl_idx), .i_wdata(i_head.tbl_val),
        .i_re(en), .i_raddr0(ra[0]), .i_raddr1(ra[0] + IW'(1)),
        .o_rdata0(rd[0][0]), .o_rdata1(rd[0][1]));

    gn3_ram #(.WIDTH(BW), .DEPTH(gn3_pkg::TABLE_DEPTH)) u_ram1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(r1_item.tbl_idx), .i_wdata(r1_item.tbl_val),
        .i_re(en), .i_raddr0(ra[1]), .i_raddr1(ra[1] + IW'(1)),
        .o_rdata0(rd[1][0]), .o_rdata1(rd[1][1]));

    gn3_ram #(.WIDTH(BW), .DEPTH(gn3_pkg::TABLE_DEPTH)) u_ram2 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(r1_item.tbl_idx), .i_wdata(r1_item.tbl_val),
        .i_re(en), .i_raddr0(ra[2]), .i_raddr1(ra[2] + IW'(1)),
        .o_rdata0(rd[2][0]), .o_rdata1(rd[2][1]));

    gn3_ram #(.WIDTH(BW), .DEPTH(gn3_pkg::TABLE_DEPTH)) u_ram3 (
        .i_clk(i_clk), .i_we(we2), .i_waddr(r2_item.tbl_idx), .i_wdata(r2_item.tbl_val),
        .i_re(en), .i_raddr0(ra[3]), .i_raddr1(ra[3] + IW'(1)),
        .o_rdata0(rd[3][0]), .o_rdata1(rd[3][1]));

    gn3_ram #(.WIDTH(BW), .DEPTH(gn3_pkg::TABLE_DEPTH)) u_ram4 (
        .i_clk(i_clk), .i_we(we2), .i_waddr(r2_item.tbl_idx), .i_wdata(r2_item.tbl_val),
        .i_re(en), .i_raddr0(ra[4]), .i_raddr1(ra[4] + IW'(1)),
        .o_rdata0(rd[4][0]), .o_rdata1(rd[4][1]));

    gn3_ram #(.WIDTH(BW), .DEPTH(gn3_pkg::TABLE_DEPTH)) u_ram5 (
        .i_clk(i_clk), .i_we(we2), .i_waddr(r2_item.tbl_idx), .i_wdata(r2_item.tbl_val),
        .i_re(en), .i_raddr0(ra[5]), .i_raddr1(ra[5] + IW'(1)),
        .o_rdata0(rd[5][0]), .o_rdata1(rd[5][1]));

    gn3_ram #(.WIDTH(BW), .DEPTH(gn3_pkg::TABLE_DEPTH)) u_ram6 (
        .i_clk(i_clk), .i_we(we2), .i_waddr(r2_item.tbl_idx), .i_wdata(r2_item.tbl_val),
        .i_re(en), .i_raddr0(ra[6]), .i_raddr1(ra[6] + IW'(1)),
        .o_rdata0(rd[6][0]), .o_rdata1(rd[6][1]));

    // fade step one: t*(6t-15) and t*t
    always_comb begin
        logic signed [AW-1:0]   ts;
        logic signed [AW-1:0]   a;
        logic signed [2*AW-1:0] p;
        logic [2*F:0]           q;
        for (int i = 0; i < 3; i++) begin
            ts = AW'(i_head.frac[i]);
            a  = (ts <<< 2) + (ts <<< 1) - AW'(15 * gn3_pkg::ONE);
            p  = ts * a;
            p  = p + (2*AW)'(gn3_pkg::HALF);
            w_ta[i] = p[F +: AW];
            q  = (2*F+1)'(i_head.frac[i]) * (2*F+1)'(i_head.frac[i]);
            q  = q + (2*F+1)'(gn3_pkg::HALF);
            w_t2[i] = q[F +: F+1];
        end
    end

    // fade step two: b = t*a + 10 and t^3
    always_comb begin
        logic [2*F+1:0] q;
        for (int i = 0; i < 3; i++) begin
            w_b[i] = r1_ta[i] + AW'(10 * gn3_pkg::ONE);
            q = (2*F+2)'(r1_t2[i]) * (2*F+2)'(r1_item.frac[i]);
            q = q + (2*F+2)'(gn3_pkg::HALF);
            w_t3[i] = q[F +: F+1];
        end
    end

    // fade step three: t^3 * b
    always_comb begin
        logic signed [AW-1:0]   ts;
        logic signed [2*AW-1:0] p;
        for (int i = 0; i < 3; i++) begin
            ts = AW'(r2_t3[i]);
            p  = ts * r2_b[i];
            p  = p + (2*AW)'(gn3_pkg::HALF);
            w_fd[i] = p[F +: FDW];
        end
    end

    // corner gradients, corner bits are x, y, z offsets
    always_comb begin
        logic signed [VW-1:0] c0 [3];
        logic signed [VW-1:0] c1 [3];
        logic [BW-1:0]        h;
        for (int i = 0; i < 3; i++) begin
            c0[i] = VW'(r3_frac[i]);
            c1[i] = c0[i] - VW'(gn3_pkg::ONE);
        end
        for (int k = 0; k < 8; k++) begin
            h = rd[3 + 2 * (k & 1) + ((k >> 1) & 1)][(k >> 2) & 1];
            w_g[k] = grad(h[3:0], (k & 1) != 0 ? c1[0] : c0[0],
                          (k & 2) != 0 ? c1[1] : c0[1],
                          (k & 4) != 0 ? c1[2] : c0[2]);
        end
    end

    // map to zero..one in sixteen fraction bits
    always_comb begin
        logic signed [OW-1:0] val;
        val = OW'(r7_n) + OW'(gn3_pkg::ONE);
        val = (val + OW'(gn3_pkg::RND)) >>> gn3_pkg::OSH;
        val = val <<< gn3_pkg::OML;
        if (val < 0) begin
            w_out = '0;
        end else if (val > gn3_pkg::NOISE_MAX) begin
            w_out = gn3_pkg::NOISE_W'(gn3_pkg::NOISE_MAX);
        end else begin
            w_out = val[gn3_pkg::NOISE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_eval    <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[6:1], i_head_vld};
            r_eval    <= {r_eval[6:1], i_head.is_eval};
            r_out_vld <= r_vld[7] && r_eval[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_item <= i_head;
            r2_item <= r1_item;
            r3_frac <= r2_item.frac;
            for (int i = 0; i < 3; i++) begin
                r1_ta[i] <= w_ta[i];
                r1_t2[i] <= w_t2[i];
                r2_b[i]  <= w_b[i];
                r2_t3[i] <= w_t3[i];
                r3_fd[i] <= w_fd[i];
                r4_fd[i] <= r3_fd[i];
                r5_fd[i] <= r4_fd[i];
                r6_fd[i] <= r5_fd[i];
            end
            for (int k = 0; k < 8; k++) begin
                r4_g[k] <= w_g[k];
            end
            for (int j = 0; j < 4; j++) begin
                r5_l[j] <= lerp(r4_g[2*j], r4_g[2*j+1], r4_fd[0]);
            end
            for (int j = 0; j < 2; j++) begin
                r6_m[j] <= lerp(r5_l[2*j], r5_l[2*j+1], r5_fd[1]);
            end
            r7_n  <= lerp(r6_m[0], r6_m[1], r6_fd[2]);
            r_out <= w_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_noise = r_out;

    a_eval_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vld[7] && r_eval[7]) |=> r_out_vld)
        else $error("evaluate item lost at output");

    a_write_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !(r_vld[7] && r_eval[7])) |=> !r_out_vld)
        else $error("output word without evaluate item");

    a_noise_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> r_out <= gn3_pkg::NOISE_W'(gn3_pkg::NOISE_MAX))
        else $error("noise beyond saturation bound");

endmodule
